/* rtl/dit_pkg.sv */
`timescale 1ns / 1ps

package dit_pkg;

  typedef enum logic {
    OP_ADD  = 1'b0,
    OP_LIST = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_ADDED = 2'd0,
    ST_FULL  = 2'd1,
    ST_ENTRY = 2'd2,
    ST_EMPTY = 2'd3
  } status_e;

  localparam int unsigned ValW   = 32;
  localparam int unsigned EntryW = 2 * ValW;

  // Compare unit result for one stored interval against the request value
  typedef struct packed {
    logic            reach;  // end + 1 >= v
    logic            touch;  // start <= v + 1
    logic [ValW-1:0] lo;     // min(start, v)
    logic [ValW-1:0] hi;     // max(end, v)
  } cmp_res_t;

endpackage

/* rtl/disjoint_interval_tracker.sv */
`timescale 1ns / 1ps
// Channel   Direction  Ports                                           Handshake
// request   in         operation_i, value_i                            start_i & !busy_o
// result    out        status_o, interval_start_o, interval_end_o,     result_valid_o
//                      interval_count_o, last_o                        (one cycle, no stall)
//
// Sequence: busy_o rises the cycle after a request is taken. An add scans the
//   table one entry per cycle through a single shared compare unit and stops
//   once the merge run closes. It then moves the k tail entries one per cycle
//   and writes back the merged or new entry. A list streams one result per
//   cycle. An empty list never raises busy_o. A dropped add on a full table
//   scans until no entry can be touched and skips the shift and write-back.
//   The last result is valid in the first cycle with busy_o low.
// Reset: entry count and sequencer clear; table contents stay undefined, only
//   entries below the count are ever read.
// Stalls: the receiver cannot stall; busy_o is high while a request runs.

module disjoint_interval_tracker
  import dit_pkg::*;
#(
  parameter int unsigned MAX_INTERVALS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic        operation_i,
  input  logic [31:0] value_i,
  output logic        result_valid_o,
  output logic [1:0]  status_o,
  output logic [31:0] interval_start_o,
  output logic [31:0] interval_end_o,
  output logic [5:0]  interval_count_o,
  output logic        last_o
);

  localparam int unsigned AW = (MAX_INTERVALS > 1) ? $clog2(MAX_INTERVALS) : 1;
  localparam int unsigned CW = $clog2(MAX_INTERVALS + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_WRITE,
    S_LIST
  } state_e;

  state_e state_q, state_d;

  // table size and per-request context
  logic [CW-1:0]   n_q, n_d;
  logic [ValW-1:0] v_q, v_d;
  logic [CW-1:0]   i_q, i_d;      // first entry reaching v (n if none)
  logic [CW-1:0]   m_q, m_d;      // merged entries
  logic [AW-1:0]   dn_q, dn_d;    // m-1, the down-shift distance
  logic [ValW-1:0] s_q, s_d, e_q, e_d;
  logic            found_q, found_d;
  logic            done_q, done_d;
  logic            up_q, up_d;    // insert: tail moves up, read descending

  // read pipeline
  logic [AW-1:0]   rd_addr_q, rd_addr_d;
  logic [CW-1:0]   rd_left_q, rd_left_d;
  logic            pend_q, pend_d;
  logic [AW-1:0]   pend_addr_q, pend_addr_d;

  // result register
  logic            rv_q, rv_d;
  logic [1:0]      st_q, st_d;
  logic [ValW-1:0] os_q, os_d, oe_q, oe_d;
  logic [CW-1:0]   oc_q, oc_d;
  logic            ol_q, ol_d;

  // RAM port
  logic              we;
  logic [AW-1:0]     waddr;
  logic [EntryW-1:0] wdata, rdata;
  logic [ValW-1:0]   r_start, r_end;
  cmp_res_t          cmp;

  assign r_start = rdata[EntryW-1:ValW];
  assign r_end   = rdata[ValW-1:0];

  dit_ram #(
    .WIDTH (EntryW),
    .DEPTH (MAX_INTERVALS)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (rd_addr_q),
    .rdata_o (rdata)
  );

  dit_cmp u_cmp (
    .value_i     (v_q),
    .ent_start_i (r_start),
    .ent_end_i   (r_end),
    .res_o       (cmp)
  );

  logic [CW-1:0] n_minus1;
  logic [CW-1:0] pend_next;
  logic [CW-1:0] i_plus_m;
  logic          rd_run_done;
  logic [CW+5:0] count_wide;

  assign n_minus1    = n_q - CW'(1);
  assign pend_next   = CW'(pend_addr_q) + CW'(1);
  assign i_plus_m    = i_q + m_q;
  assign rd_run_done = (rd_left_q == '0) && !pend_q;

  always_comb begin
    state_d     = state_q;
    n_d         = n_q;
    v_d         = v_q;
    i_d         = i_q;
    m_d         = m_q;
    dn_d        = dn_q;
    s_d         = s_q;
    e_d         = e_q;
    found_d     = found_q;
    done_d      = done_q;
    up_d        = up_q;
    rd_addr_d   = rd_addr_q;
    rd_left_d   = rd_left_q;
    pend_d      = 1'b0;
    pend_addr_d = pend_addr_q;
    rv_d        = 1'b0;
    st_d        = st_q;
    os_d        = os_q;
    oe_d        = oe_q;
    oc_d        = oc_q;
    ol_d        = ol_q;
    we          = 1'b0;
    waddr       = pend_addr_q;
    wdata       = rdata;

    // issue the next table read in any streaming state
    if ((state_q == S_SCAN || state_q == S_SHIFT || state_q == S_LIST) &&
        rd_left_q != '0) begin
      pend_d      = 1'b1;
      pend_addr_d = rd_addr_q;
      rd_left_d   = rd_left_q - CW'(1);
      rd_addr_d   = up_q ? rd_addr_q - AW'(1) : rd_addr_q + AW'(1);
    end

    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          v_d       = value_i;
          rd_addr_d = '0;
          rd_left_d = n_q;
          up_d      = 1'b0;
          if (operation_i == OP_LIST) begin
            if (n_q == '0) begin
              rv_d = 1'b1;
              st_d = ST_EMPTY;
              os_d = '0;
              oe_d = '0;
              oc_d = '0;
              ol_d = 1'b1;
            end else begin
              state_d = S_LIST;
            end
          end else begin
            found_d = 1'b0;
            done_d  = 1'b0;
            m_d     = '0;
            i_d     = n_q;
            state_d = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        if (pend_q && !done_q) begin
          if (!found_q) begin
            if (cmp.reach) begin
              found_d = 1'b1;
              i_d     = CW'(pend_addr_q);
              if (cmp.touch) begin
                m_d = CW'(1);
                s_d = cmp.lo;
                e_d = cmp.hi;
              end else begin
                done_d = 1'b1;
              end
            end
          end else if (cmp.touch) begin
            m_d = m_q + CW'(1);
            e_d = cmp.hi;
          end else begin
            done_d = 1'b1;
          end
        end
        if (rd_run_done || done_q) begin
          pend_d = 1'b0;
          if (m_q == '0) begin
            if (n_q >= CW'(MAX_INTERVALS)) begin
              rv_d    = 1'b1;
              st_d    = ST_FULL;
              os_d    = '0;
              oe_d    = '0;
              oc_d    = n_q;
              ol_d    = 1'b1;
              state_d = S_IDLE;
            end else begin
              up_d      = 1'b1;
              s_d       = v_q;
              e_d       = v_q;
              rd_addr_d = n_minus1[AW-1:0];
              rd_left_d = n_q - i_q;
              state_d   = S_SHIFT;
            end
          end else begin
            up_d      = 1'b0;
            dn_d      = AW'(m_q - CW'(1));
            rd_addr_d = i_plus_m[AW-1:0];
            rd_left_d = n_q - i_plus_m;
            state_d   = S_SHIFT;
          end
        end
      end

      S_SHIFT: begin
        if (pend_q) begin
          we    = 1'b1;
          waddr = up_q ? pend_addr_q + AW'(1) : pend_addr_q - dn_q;
          wdata = rdata;
        end
        if (rd_run_done) begin
          state_d = S_WRITE;
        end
      end

      S_WRITE: begin
        we      = 1'b1;
        waddr   = i_q[AW-1:0];
        wdata   = {s_q, e_q};
        n_d     = up_q ? n_q + CW'(1) : n_q - CW'(dn_q);
        rv_d    = 1'b1;
        st_d    = ST_ADDED;
        os_d    = s_q;
        oe_d    = e_q;
        oc_d    = n_d;
        ol_d    = 1'b1;
        state_d = S_IDLE;
      end

      S_LIST: begin
        if (pend_q) begin
          rv_d = 1'b1;
          st_d = ST_ENTRY;
          os_d = r_start;
          oe_d = r_end;
          oc_d = n_q;
          ol_d = (pend_next == n_q);
          if (rd_left_q == '0) begin
            state_d = S_IDLE;
          end
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      n_q     <= '0;
      pend_q  <= 1'b0;
      rv_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      n_q     <= n_d;
      pend_q  <= pend_d;
      rv_q    <= rv_d;
    end
  end

  // datapath and result payload, no reset needed
  always_ff @(posedge clk_i) begin
    v_q         <= v_d;
    i_q         <= i_d;
    m_q         <= m_d;
    dn_q        <= dn_d;
    s_q         <= s_d;
    e_q         <= e_d;
    found_q     <= found_d;
    done_q      <= done_d;
    up_q        <= up_d;
    rd_addr_q   <= rd_addr_d;
    rd_left_q   <= rd_left_d;
    pend_addr_q <= pend_addr_d;
    st_q        <= st_d;
    os_q        <= os_d;
    oe_q        <= oe_d;
    oc_q        <= oc_d;
    ol_q        <= ol_d;
  end

  // count port is 6 bits, masked when the table can hold 64
  assign count_wide = {6'd0, oc_q};

  assign busy_o           = (state_q != S_IDLE);
  assign result_valid_o   = rv_q;
  assign status_o         = st_q;
  assign interval_start_o = os_q;
  assign interval_end_o   = oe_q;
  assign interval_count_o = count_wide[5:0];
  assign last_o           = ol_q;

endmodule

/* rtl/dit_ram.sv */
`timescale 1ns / 1ps

module dit_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 32
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

/* rtl/dit_cmp.sv */
`timescale 1ns / 1ps

module dit_cmp
  import dit_pkg::*;
(
  input  logic [ValW-1:0] value_i,
  input  logic [ValW-1:0] ent_start_i,
  input  logic [ValW-1:0] ent_end_i,
  output cmp_res_t        res_o
);

  logic [ValW:0] v_ext, v_plus, e_plus;

  // 33-bit adjacency tests, no wrap at the top of the range
  assign v_ext  = {1'b0, value_i};
  assign v_plus = v_ext + {{ValW{1'b0}}, 1'b1};
  assign e_plus = {1'b0, ent_end_i} + {{ValW{1'b0}}, 1'b1};

  always_comb begin
    res_o.reach = (e_plus >= v_ext);
    res_o.touch = ({1'b0, ent_start_i} <= v_plus);
    res_o.lo    = (value_i < ent_start_i) ? value_i : ent_start_i;
    res_o.hi    = (value_i > ent_end_i) ? value_i : ent_end_i;
  end

endmodule
